@@ design/id3fx_pkg.sv @@
// Shared types and constants for the ID3v2 frame extractor.
// Word layouts, parser phase and result kind codes. No dependencies.
package id3fx_pkg;

    localparam int unsigned TagHdrLen   = 10;
    localparam int unsigned FrameHdrLen = 10;

    localparam logic [31:0] TargetIdReset = 32'h5449_5432;

    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_FRAME   = 3'd1;
    localparam logic [2:0] PH_CONTENT = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_IDLE    = 3'd4;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
        logic       end_of_file;
    } t_in_word;

    typedef struct packed {
        logic [7:0] content_byte;
        logic [1:0] result_kind;
        logic       is_last;
    } t_out_word;

    typedef struct packed {
        logic     has_result;
        t_out_word word;
    } t_step_res;

endpackage

@@ design/id3fx_frame_extractor_unit.sv @@
// Top level of the ID3v2 frame extractor: input register, parser, result register.
// Depends on id3fx_pkg, id3fx_in_stage, id3fx_parser and id3fx_out_stage.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_word) takes one file byte
//   per word with start and end of file flags. The output channel
//   (o_out_valid / i_out_ready / o_out_word) gives content bytes of the frame
//   whose ID equals the target register, or a single empty or not-found status.
//   The target ID is written through i_cfg_wr_en / i_cfg_wr_data while idle.
// Dataflow and throughput:
//   An accepted byte sits in the input register; its parser step loads any result into
//   the result register. One parser step per byte, one byte per cycle unless stalled.
// Reset:
//   Both registers empty, parser at the tag header, target ID back to "TIT2".
// Stall:
//   While a result waits on i_out_ready, the held byte is parsed only once the
//   result register frees; the input register then fills and o_in_ready drops.
module id3_frame_extractor_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [31:0]          i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  id3fx_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output id3fx_pkg::t_out_word o_out_word
);

    logic                 in_valid;
    id3fx_pkg::t_in_word  in_word;
    logic                 step;
    id3fx_pkg::t_step_res res;

    assign step = in_valid && (!o_out_valid || i_out_ready);

    id3fx_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_word    (i_in_word),
        .i_consume (step),
        .o_valid   (in_valid),
        .o_word    (in_word)
    );

    id3fx_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_word        (in_word),
        .o_res         (res)
    );

    id3fx_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res.has_result),
        .i_word  (res.word),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

endmodule

@@ design/id3fx_in_stage.sv @@
// Input register of the ID3v2 frame extractor.
// Holds one accepted word until the parser consumes it. Uses id3fx_pkg.
module id3fx_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  id3fx_pkg::t_in_word i_word,
    input  logic                i_consume,
    output logic                o_valid,
    output id3fx_pkg::t_in_word o_word
);

    logic                r_valid;
    id3fx_pkg::t_in_word r_word;

    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

@@ design/id3fx_parser.sv @@
// Parser state and per-byte step logic of the ID3v2 frame extractor.
// Holds the target ID register and the tag/frame walk state. Uses id3fx_pkg.
module id3fx_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [31:0]          i_cfg_wr_data,
    input  logic                 i_step,
    input  id3fx_pkg::t_in_word  i_word,
    output id3fx_pkg::t_step_res o_res
);

    logic [31:0] r_target;
    logic [2:0]  r_phase;
    logic [3:0]  r_hdr_idx;
    logic [29:0] r_pos;
    logic [27:0] r_tag_len;
    logic [31:0] r_name;
    logic [31:0] r_remain;

    logic [2:0]  n_phase;
    logic [3:0]  n_hdr_idx;
    logic [29:0] n_pos;
    logic [27:0] n_tag_len;
    logic [31:0] n_name;
    logic [31:0] n_remain;

    logic [2:0]  b_phase;
    logic [3:0]  b_hdr_idx;
    logic [29:0] b_pos;
    logic [27:0] b_tag_len;
    logic [31:0] b_name;
    logic [31:0] b_remain;

    logic        have;
    logic [1:0]  kind;
    logic [7:0]  cbyte;
    logic        last;
    logic        tag_end;
    logic [28:0] tag_limit;

    always_comb begin
        if (i_word.start_of_file) begin
            b_phase   = id3fx_pkg::PH_TAG;
            b_hdr_idx = '0;
            b_pos     = '0;
            b_tag_len = '0;
            b_name    = '0;
            b_remain  = '0;
        end else begin
            b_phase   = r_phase;
            b_hdr_idx = r_hdr_idx;
            b_pos     = r_pos;
            b_tag_len = r_tag_len;
            b_name    = r_name;
            b_remain  = r_remain;
        end

        n_phase   = b_phase;
        n_hdr_idx = b_hdr_idx;
        n_pos     = b_pos;
        n_tag_len = b_tag_len;
        n_name    = b_name;
        n_remain  = b_remain;
        have      = 1'b0;
        kind      = id3fx_pkg::KIND_NONE;
        cbyte     = '0;
        last      = 1'b1;
        tag_end   = 1'b0;
        tag_limit = '0;

        if (b_phase != id3fx_pkg::PH_IDLE) begin
            if (b_pos != '1) begin
                n_pos = b_pos + 30'd1;
            end
            if (b_phase == id3fx_pkg::PH_TAG && b_hdr_idx >= 4'd6) begin
                n_tag_len = {b_tag_len[20:0], i_word.data_byte[6:0]};
            end
            tag_limit = {1'b0, n_tag_len} + 29'(id3fx_pkg::TagHdrLen);
            tag_end   = n_pos >= {1'b0, tag_limit};

            unique case (b_phase)
                id3fx_pkg::PH_TAG: begin
                    n_hdr_idx = b_hdr_idx + 4'd1;
                    if (n_hdr_idx >= 4'(id3fx_pkg::TagHdrLen)) begin
                        if (tag_end) begin
                            n_phase = id3fx_pkg::PH_IDLE;
                            have    = 1'b1;
                        end else begin
                            n_phase   = id3fx_pkg::PH_FRAME;
                            n_hdr_idx = '0;
                        end
                    end
                end
                id3fx_pkg::PH_FRAME: begin
                    if (b_hdr_idx < 4'd4) begin
                        n_name = {b_name[23:0], i_word.data_byte};
                    end else if (b_hdr_idx < 4'd8) begin
                        n_remain = {b_remain[23:0], i_word.data_byte};
                    end
                    n_hdr_idx = b_hdr_idx + 4'd1;
                    if (n_hdr_idx >= 4'(id3fx_pkg::FrameHdrLen)) begin
                        if (n_name == r_target) begin
                            if (n_remain == '0) begin
                                have    = 1'b1;
                                kind    = id3fx_pkg::KIND_EMPTY;
                                n_phase = id3fx_pkg::PH_IDLE;
                            end else begin
                                n_phase = id3fx_pkg::PH_CONTENT;
                            end
                        end else if (n_remain == '0) begin
                            if (tag_end) begin
                                n_phase = id3fx_pkg::PH_IDLE;
                                have    = 1'b1;
                            end else begin
                                n_phase   = id3fx_pkg::PH_FRAME;
                                n_hdr_idx = '0;
                            end
                        end else begin
                            n_phase = id3fx_pkg::PH_SKIP;
                        end
                    end
                end
                id3fx_pkg::PH_CONTENT: begin
                    have     = 1'b1;
                    kind     = id3fx_pkg::KIND_BYTE;
                    cbyte    = i_word.data_byte;
                    n_remain = b_remain - 32'd1;
                    if (n_remain == '0) begin
                        n_phase = id3fx_pkg::PH_IDLE;
                    end else begin
                        last = 1'b0;
                    end
                end
                id3fx_pkg::PH_SKIP: begin
                    n_remain = b_remain - 32'd1;
                    if (n_remain == '0) begin
                        if (tag_end) begin
                            n_phase = id3fx_pkg::PH_IDLE;
                            have    = 1'b1;
                        end else begin
                            n_phase   = id3fx_pkg::PH_FRAME;
                            n_hdr_idx = '0;
                        end
                    end
                end
                default: begin
                    n_phase = id3fx_pkg::PH_IDLE;
                end
            endcase

            if (i_word.end_of_file && (b_phase <= id3fx_pkg::PH_SKIP)) begin
                if (!have) begin
                    kind  = id3fx_pkg::KIND_NONE;
                    cbyte = '0;
                end
                have    = 1'b1;
                last    = 1'b1;
                n_phase = id3fx_pkg::PH_IDLE;
            end
        end

        o_res.has_result        = have;
        o_res.word.content_byte = cbyte;
        o_res.word.result_kind  = kind;
        o_res.word.is_last      = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= id3fx_pkg::TargetIdReset;
        end else if (i_cfg_wr_en) begin
            r_target <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= id3fx_pkg::PH_TAG;
            r_hdr_idx <= '0;
            r_pos     <= '0;
            r_tag_len <= '0;
            r_name    <= '0;
            r_remain  <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_pos     <= n_pos;
            r_tag_len <= n_tag_len;
            r_name    <= n_name;
            r_remain  <= n_remain;
        end
    end

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.has_result && o_res.word.result_kind != id3fx_pkg::KIND_BYTE)
        |-> (o_res.word.content_byte == 8'd0 && o_res.word.is_last))
        else $error("status result carries data or is not last");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.has_result && o_res.word.is_last)
        |=> (r_phase == id3fx_pkg::PH_IDLE))
        else $error("parser not idle after last result");

    a_tag_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == id3fx_pkg::PH_TAG) |-> (r_hdr_idx < 4'(id3fx_pkg::TagHdrLen)))
        else $error("tag header index overrun");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == id3fx_pkg::PH_SKIP || r_phase == id3fx_pkg::PH_CONTENT)
        |-> (r_remain != 32'd0))
        else $error("skip or content with nothing remaining");

endmodule

@@ design/id3fx_out_stage.sv @@
// Result register of the ID3v2 frame extractor.
// Holds one result word until the receiver takes it. Uses id3fx_pkg.
module id3fx_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  id3fx_pkg::t_out_word i_word,
    input  logic                 i_ready,
    output logic                 o_valid,
    output id3fx_pkg::t_out_word o_word
);

    logic                 r_valid;
    id3fx_pkg::t_out_word r_word;

    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

endmodule
